// ===== rtl/flsr_pkg.sv =====
// ----------------------------------------------------------------------------
// flsr_pkg
// Shared types, constants and step functions for the filtered LFSR word
// step and rollback pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package flsr_pkg;

  // feedback taps and filter truth tables
  localparam logic [23:0] TAPS_ODD  = 24'h29CE5C;
  localparam logic [23:0] TAPS_EVEN = 24'h870804;
  localparam logic [15:0] TAB_A     = 16'h9E98;
  localparam logic [15:0] TAB_C     = 16'hB48E;
  localparam logic [31:0] TAB_E     = 32'hEC57E80A;

  // pipeline shape: eight stages of four steps each
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES      = 8;

  // direction codes
  localparam logic KIND_FORWARD  = 1'b0;
  localparam logic KIND_ROLLBACK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [23:0] odd_state;
    logic [23:0] even_state;
    logic [31:0] in_word;
    logic        encrypted;
  } flsr_item_t;

  typedef struct packed {
    logic [23:0] odd_out;
    logic [23:0] even_out;
    logic [31:0] keystream;
  } flsr_result_t;

  // transaction as it travels down the pipeline: word is consumed from
  // bit 0, keystream fills from bit 31 downwards
  typedef struct packed {
    logic        kind;
    logic        encrypted;
    logic [23:0] odd_half;
    logic [23:0] even_half;
    logic [31:0] word;
    logic [31:0] ks;
  } flsr_stage_t;

  typedef struct packed {
    logic [23:0] odd_half;
    logic [23:0] even_half;
    logic        ks_bit;
  } flsr_step_t;

  // nonlinear filter over seventeen bits of the odd half
  function automatic logic filt(input logic [23:0] o);
    logic       a;
    logic       b;
    logic       c;
    logic       d;
    logic [4:0] idx;
    a   = TAB_A[{o[6], o[4], o[2], o[0]}];
    b   = TAB_A[{o[14], o[12], o[10], o[8]}];
    c   = TAB_C[{o[22], o[20], o[18], o[16]}];
    d   = TAB_C[{o[7], o[5], o[3], o[1]}];
    idx = {o[17], d, c, b, a};
    return TAB_E[idx];
  endfunction

  // one clocking of the register, forward or undone
  function automatic flsr_step_t lfsr_step(input logic        kind,
                                           input logic        enc,
                                           input logic [23:0] odd_half,
                                           input logic [23:0] even_half,
                                           input logic        in_bit);
    flsr_step_t  r;
    logic        o;
    logic        feed;
    logic        fb;
    logic [22:0] lo;
    if (kind == KIND_ROLLBACK) begin
      lo   = odd_half[23:1];
      o    = filt(even_half);
      feed = in_bit ^ (enc & o);
      fb   = odd_half[0] ^ (^({1'b0, lo} & TAPS_EVEN)) ^ (^(even_half & TAPS_ODD)) ^ feed;
      r.odd_half  = even_half;
      r.even_half = {fb, lo};
    end else begin
      lo   = even_half[22:0];
      o    = filt(odd_half);
      feed = in_bit ^ (enc & o);
      fb   = (^(even_half & TAPS_EVEN)) ^ (^(odd_half & TAPS_ODD)) ^ feed;
      r.odd_half  = {lo, fb};
      r.even_half = odd_half;
    end
    r.ks_bit = o;
    return r;
  endfunction

  // bit reversal of a word, pure wiring
  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/flsr_stage.sv =====
// ----------------------------------------------------------------------------
// flsr_stage
// One pipeline stage: four LFSR steps and a register with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module flsr_stage (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  flsr_pkg::flsr_stage_t in_data,
  output logic                  in_ready,
  output logic                  out_valid,
  output flsr_pkg::flsr_stage_t out_data,
  input  wire                   out_ready
);

  logic                  valid;
  flsr_pkg::flsr_stage_t data;
  flsr_pkg::flsr_stage_t data_next;

  // four dependent steps, each eats the low word bit
  always_comb begin
    flsr_pkg::flsr_step_t s;
    data_next = in_data;
    for (int j = 0; j < flsr_pkg::STEPS_PER_STAGE; j++) begin
      s = flsr_pkg::lfsr_step(data_next.kind, data_next.encrypted,
                              data_next.odd_half, data_next.even_half,
                              data_next.word[0]);
      data_next.odd_half  = s.odd_half;
      data_next.even_half = s.even_half;
      data_next.word      = {1'b0, data_next.word[31:1]};
      data_next.ks        = {s.ks_bit, data_next.ks[31:1]};
    end
  end

  // stage loads when empty or when its contents move on
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

// ===== rtl/filtered_lfsr_word_step_and_rollback_core.sv =====
// Eight stages of four LFSR steps; a result is valid once it has left the last one.
// Throughput: one transaction per cycle while result_stall is low.
// Each stage register loads when empty or when it drains, so bubbles close
// up and the input is stalled only when all eight stages hold results.
// Reset (rst, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// filtered_lfsr_word_step_and_rollback_core
// 32-step forward or rollback of a filtered 48-bit LFSR with keystream out.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_lfsr_word_step_and_rollback_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  flsr_pkg::flsr_item_t   item,
  output logic                   result_valid,
  input  wire                    result_stall,
  output flsr_pkg::flsr_result_t result
);

  localparam int unsigned N = flsr_pkg::NUM_STAGES;

  logic                  valid_c [N+1];
  logic                  ready_c [N+1];
  flsr_pkg::flsr_stage_t data_c  [N+1];

  // entry: rollback consumes the word from the top, so reverse it
  always_comb begin
    data_c[0].kind      = item.kind;
    data_c[0].encrypted = item.encrypted;
    data_c[0].odd_half  = item.odd_state;
    data_c[0].even_half = item.even_state;
    data_c[0].word      = (item.kind == flsr_pkg::KIND_ROLLBACK) ?
                          flsr_pkg::rev32(item.in_word) : item.in_word;
    data_c[0].ks        = '0;
  end
  assign valid_c[0] = item_valid;
  assign item_stall = !ready_c[0];

  // stage chain
  for (genvar k = 0; k < N; k++) begin : g_stage
    flsr_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[k]),
      .in_data   (data_c[k]),
      .in_ready  (ready_c[k]),
      .out_valid (valid_c[k+1]),
      .out_data  (data_c[k+1]),
      .out_ready (ready_c[k+1])
    );
  end

  // output side: keystream back into step order for rollback
  assign ready_c[N]       = !result_stall;
  assign result_valid     = valid_c[N];
  assign result.odd_out   = data_c[N].odd_half;
  assign result.even_out  = data_c[N].even_half;
  assign result.keystream = (data_c[N].kind == flsr_pkg::KIND_ROLLBACK) ?
                            flsr_pkg::rev32(data_c[N].ks) : data_c[N].ks;

endmodule

`default_nettype wire

// ===== rtl/flsr_checker.sv =====
// ----------------------------------------------------------------------------
// flsr_checker
// Port-level checks on the LFSR pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flsr_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    item_valid,
  input wire                    item_stall,
  input wire                    result_valid,
  input wire                    result_stall,
  input flsr_pkg::flsr_result_t result
);

  logic       in_acc;
  logic       out_acc;
  logic       flowing;
  logic [3:0] pending;

  assign in_acc  = item_valid && !item_stall;
  assign out_acc = result_valid && !result_stall;
  assign flowing = !result_stall && !rst;

  // transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'b0, in_acc} - {3'b0, out_acc};
    end
  end

  // never more in flight than stages
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(flsr_pkg::NUM_STAGES))
    else $error("more transactions in flight than pipeline stages");

  // no result without a transaction in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 4'd0)
    else $error("result delivered with nothing in flight");

  // input is held back only by a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while output side can drain");

  // with a free-running output the result shows once it has passed every stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(in_acc && !rst, 8) && $past(flowing, 8) && $past(flowing, 7) &&
     $past(flowing, 6) && $past(flowing, 5) && $past(flowing, 4) &&
     $past(flowing, 3) && $past(flowing, 2) && $past(flowing, 1)) |-> result_valid)
    else $error("result missing eight cycles after acceptance");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind filtered_lfsr_word_step_and_rollback_core flsr_checker u_flsr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the filtered LFSR word step and rollback core.
// Every accepted transaction is run through a bit-level model of the 32-step
// forward or rollback walk. The expected state halves and keystream are
// queued and compared field by field with each accepted result. Both sides
// idle and stall at random, with quiet phases at full rate in between.
// ----------------------------------------------------------------------------
module testbench;

  // own copies of the register taps and filter tables
  localparam logic [23:0] FB_TAPS_ODD  = 24'h29CE5C;
  localparam logic [23:0] FB_TAPS_EVEN = 24'h870804;
  localparam logic [15:0] FILT_AB      = 16'h9E98;
  localparam logic [15:0] FILT_CD      = 16'hB48E;
  localparam logic [31:0] FILT_OUT     = 32'hEC57E80A;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          RANDOM_ITEMS   = 800;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  flsr_pkg::flsr_item_t   item;
  logic                   result_valid;
  logic                   result_stall;
  flsr_pkg::flsr_result_t result;

  flsr_pkg::flsr_result_t pending_results[$];
  int           mismatches  = 0;
  int           results_seen = 0;
  int           n_forward   = 0;
  int           n_rollback  = 0;
  int           n_encrypted = 0;
  int           idle_cycles = 0;
  bit           tx_idle = 1'b1;
  bit           rx_idle = 1'b1;

  filtered_lfsr_word_step_and_rollback_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // clock
  always #5 clk = ~clk;

  // nonlinear filter over seventeen bits of the odd half
  function automatic logic filter_bit(input logic [23:0] o);
    logic [3:0] sel_a;
    logic [3:0] sel_b;
    logic [3:0] sel_c;
    logic [3:0] sel_d;
    logic [4:0] sel_e;
    sel_a = {o[6], o[4], o[2], o[0]};
    sel_b = {o[14], o[12], o[10], o[8]};
    sel_c = {o[22], o[20], o[18], o[16]};
    sel_d = {o[7], o[5], o[3], o[1]};
    sel_e[0] = FILT_AB[sel_a];
    sel_e[1] = FILT_AB[sel_b];
    sel_e[2] = FILT_CD[sel_c];
    sel_e[3] = FILT_CD[sel_d];
    sel_e[4] = o[17];
    return FILT_OUT[sel_e];
  endfunction

  // 32 clockings forward, or 32 undone with even bit 23 recovered
  function automatic flsr_pkg::flsr_result_t lfsr_word_calc(input flsr_pkg::flsr_item_t it);
    flsr_pkg::flsr_result_t r;
    logic [23:0]  od;
    logic [23:0]  ev;
    logic [31:0]  ks;
    logic         o;
    logic         fb;
    int           i;
    od = it.odd_state;
    ev = it.even_state;
    ks = '0;
    if (it.kind == flsr_pkg::KIND_FORWARD) begin
      for (i = 0; i < 32; i++) begin
        o  = filter_bit(od);
        fb = (^(ev & FB_TAPS_EVEN)) ^ (^(od & FB_TAPS_ODD)) ^ it.in_word[i]
             ^ (it.encrypted & o);
        {od, ev} = {ev[22:0], fb, od};
        ks[i] = o;
      end
    end else begin
      for (i = 31; i >= 0; i--) begin
        o  = filter_bit(ev);
        fb = od[0] ^ (^({1'b0, od[23:1]} & FB_TAPS_EVEN)) ^ (^(ev & FB_TAPS_ODD))
             ^ it.in_word[i] ^ (it.encrypted & o);
        {od, ev} = {ev, fb, od[23:1]};
        ks[i] = o;
      end
    end
    r.odd_out   = od;
    r.even_out  = ev;
    r.keystream = ks;
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    flsr_pkg::flsr_result_t want;
    if (!rst && item_valid && !item_stall) begin
      pending_results.push_back(lfsr_word_calc(item));
      if (item.kind == flsr_pkg::KIND_FORWARD) n_forward++;
      else n_rollback++;
      if (item.encrypted) n_encrypted++;
    end
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result.keystream, '0);
      end else begin
        want = pending_results.pop_front();
        if (result.odd_out !== want.odd_out)
          report_mismatch("odd_out", {8'h00, result.odd_out}, {8'h00, want.odd_out});
        if (result.even_out !== want.even_out)
          report_mismatch("even_out", {8'h00, result.even_out}, {8'h00, want.even_out});
        if (result.keystream !== want.keystream)
          report_mismatch("keystream", result.keystream, want.keystream);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure, one random hold per result
  initial begin
    int hold;
    result_stall = 1'b0;
    forever begin
      hold = rx_idle ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // drive one transaction; entered and left at a falling edge
  task automatic send_item(input flsr_pkg::flsr_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  function automatic flsr_pkg::flsr_item_t make_item(input logic kind,
                                                     input logic [23:0] odd_s,
                                                     input logic [23:0] even_s,
                                                     input logic [31:0] w,
                                                     input logic enc);
    flsr_pkg::flsr_item_t it;
    it.kind       = kind;
    it.odd_state  = odd_s;
    it.even_state = even_s;
    it.in_word    = w;
    it.encrypted  = enc;
    return it;
  endfunction

  function automatic flsr_pkg::flsr_item_t random_item();
    flsr_pkg::flsr_item_t it;
    it.kind       = 1'($urandom_range(0, 1));
    it.encrypted  = 1'($urandom_range(0, 1));
    it.odd_state  = 24'($urandom());
    it.even_state = 24'($urandom());
    // zero word with encryption is the common key-stream use
    it.in_word    = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
    if ($urandom_range(0, 15) == 0) it.odd_state = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 15) == 0) it.even_state = $urandom_range(0, 1) ? '1 : '0;
    return it;
  endfunction

  // forward walk followed by its rollback, which restores the start state
  task automatic send_round_trip(input flsr_pkg::flsr_item_t fwd);
    flsr_pkg::flsr_result_t mid;
    fwd.kind = flsr_pkg::KIND_FORWARD;
    mid = lfsr_word_calc(fwd);
    send_item(fwd);
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, mid.odd_out, mid.even_out, fwd.in_word,
                        fwd.encrypted));
  endtask

  // field extremes in both directions, plain and encrypted
  task automatic test_extremes();
    send_item(make_item(flsr_pkg::KIND_FORWARD,  '0, '0, '0, 1'b0));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, '0, '0, '0, 1'b0));
    send_item(make_item(flsr_pkg::KIND_FORWARD,  '1, '1, '1, 1'b0));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, '1, '1, '1, 1'b0));
    send_item(make_item(flsr_pkg::KIND_FORWARD,  '1, '1, '0, 1'b1));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, '1, '1, '0, 1'b1));
    send_item(make_item(flsr_pkg::KIND_FORWARD,  24'hAAAAAA, 24'h555555, 32'hA5A5A5A5, 1'b1));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, 24'h555555, 24'hAAAAAA, 32'h5A5A5A5A, 1'b1));
  endtask

  // single bits: top of each half, bottom and bit 17 of the odd half, first and last word bits
  task automatic test_single_bits();
    send_item(make_item(flsr_pkg::KIND_FORWARD,  24'h800000, '0, '0, 1'b0));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, '0, 24'h800000, '0, 1'b0));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, 24'h000001, '0, '0, 1'b0));
    send_item(make_item(flsr_pkg::KIND_FORWARD,  '0, '0, 32'h00000001, 1'b0));
    send_item(make_item(flsr_pkg::KIND_ROLLBACK, '0, '0, 32'h80000000, 1'b0));
    send_item(make_item(flsr_pkg::KIND_FORWARD,  24'h020000, '0, '0, 1'b1));
  endtask

  // rollback undoes a forward walk, plain and encrypted
  task automatic test_round_trips();
    send_round_trip(make_item(flsr_pkg::KIND_FORWARD, 24'h123456, 24'h89ABCD, 32'h0, 1'b1));
    send_round_trip(make_item(flsr_pkg::KIND_FORWARD, 24'hFEDCBA, 24'h765432, 32'hDEADBEEF,
                              1'b0));
    send_round_trip(make_item(flsr_pkg::KIND_FORWARD, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF,
                              1'b1));
  endtask

  // random transactions over four idling mixes
  task automatic test_random();
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / (RANDOM_ITEMS / 4))
        0: begin tx_idle = 1'b1; rx_idle = 1'b1; end
        1: begin tx_idle = 1'b0; rx_idle = 1'b0; end
        2: begin tx_idle = 1'b0; rx_idle = 1'b1; end
        default: begin tx_idle = 1'b1; rx_idle = 1'b0; end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        send_round_trip(random_item());
        i++;
      end else begin
        send_item(random_item());
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // main sequence
  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_single_bits();
    test_round_trips();
    test_random();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", pending_results.size(), 0);
    $display("ran %0d forward and %0d rollback transactions, %0d of them encrypted",
             n_forward, n_rollback, n_encrypted);
    $display("compared %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
